[design/zsc_pkg.sv]
// Package for the zip stream cipher: item kinds, key constants, CRC-32 table
// and the controller-to-datapath command type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package zsc_pkg;

	localparam int unsigned KIND_W = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KEY_W  = 32;

	localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PASSWORD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DATA     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REWIND   = 2'd3;

	localparam logic [KEY_W-1:0] KEY0_INIT = 32'h12345678;
	localparam logic [KEY_W-1:0] KEY1_INIT = 32'h23456789;
	localparam logic [KEY_W-1:0] KEY2_INIT = 32'h34567890;
	localparam logic [KEY_W-1:0] KEY1_MULT = 32'h08088405;
	localparam logic [KEY_W-1:0] CRC_POLY  = 32'hEDB88320;

	typedef logic [KEY_W-1:0] crc_table_t [256];

	function automatic crc_table_t crc_table_build();
		crc_table_t t;
		logic [KEY_W-1:0] v;
		for (int i = 0; i < 256; i++) begin
			v = KEY_W'(i);
			for (int j = 0; j < 8; j++) begin
				if (v[0]) begin
					v = (v >> 1) ^ CRC_POLY;
				end else begin
					v = v >> 1;
				end
			end
			t[i] = v;
		end
		return t;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_table_build();

	function automatic logic [KEY_W-1:0] crc_step(input logic [KEY_W-1:0] x,
			input logic [BYTE_W-1:0] b);
		return CRC_TABLE[x[7:0] ^ b] ^ {8'h00, x[KEY_W-1:8]};
	endfunction

	typedef struct packed {
		logic init_keys;
		logic rewind;
		logic step0;
		logic data;
		logic step12;
		logic save;
	} cmd_t;

endpackage
`default_nettype wire

[design/zsc_if.sv]
// Stream interfaces for the zip stream cipher: input items and result items.
// Depends on zsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface zsc_in_if;
	import zsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] byte_value;
	logic              last_in;
	modport source (output valid, kind, byte_value, last_in, input ready);
	modport sink   (input valid, kind, byte_value, last_in, output ready);
endinterface

interface zsc_out_if;
	import zsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_out;
	modport source (output valid, out_byte, last_out, input ready);
	modport sink   (input valid, out_byte, last_out, output ready);
endinterface
`default_nettype wire

[design/zsc_ctrl.sv]
// Controller for the zip stream cipher: accepts transactions, sequences the
// two key update steps and owns the result valid flag. Depends on zsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zsc_ctrl import zsc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [KIND_W-1:0] in_kind,
	output      logic              in_ready,
	input  wire logic              out_ready,
	output      logic              out_valid,
	output      cmd_t              cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_MIX
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   save_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.init_keys = accept && (in_kind == KIND_START);
		cmd.rewind    = accept && (in_kind == KIND_REWIND);
		cmd.data      = accept && (in_kind == KIND_DATA);
		cmd.step0     = accept && ((in_kind == KIND_DATA) || (in_kind == KIND_PASSWORD));
		cmd.step12    = (state_q == ST_MIX);
		cmd.save      = (state_q == ST_MIX) && save_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			save_q      <= 1'b0;
		end else begin
			if (cmd.data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.step0) begin
						state_q <= ST_MIX;
						save_q  <= (in_kind == KIND_PASSWORD);
					end
				end
				ST_MIX: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[design/zsc_datapath.sv]
// Datapath for the zip stream cipher: key words, saved copy, mode register,
// keystream generation and result register. Depends on zsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zsc_datapath import zsc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire cmd_t              cmd,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	output      logic [BYTE_W-1:0] out_byte,
	output      logic              out_last
);

	logic [KEY_W-1:0]  key0_q, key1_q, key2_q;
	logic [KEY_W-1:0]  save0_q, save1_q, save2_q;
	logic              decrypt_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic [15:0]       ks_x;
	logic [15:0]       ks_prod;
	logic [BYTE_W-1:0] res;
	logic [BYTE_W-1:0] upd_byte;
	logic [KEY_W-1:0]  key0_next;
	logic [KEY_W-1:0]  key1_next;
	logic [KEY_W-1:0]  key2_next;

	always_comb begin
		ks_x      = key2_q[15:0] | 16'h0002;
		ks_prod   = ks_x * (ks_x ^ 16'h0001);
		res       = in_byte ^ ks_prod[15:8];
		upd_byte  = (cmd.data && decrypt_q) ? res : in_byte;
		key0_next = crc_step(key0_q, upd_byte);
		key1_next = (key1_q + {24'h000000, key0_q[7:0]}) * KEY1_MULT + 32'd1;
		key2_next = crc_step(key2_q, key1_next[KEY_W-1:24]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q    <= KEY0_INIT;
			key1_q    <= KEY1_INIT;
			key2_q    <= KEY2_INIT;
			save0_q   <= KEY0_INIT;
			save1_q   <= KEY1_INIT;
			save2_q   <= KEY2_INIT;
			decrypt_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				decrypt_q <= cfg_wdata;
			end
			if (cmd.init_keys) begin
				key0_q  <= KEY0_INIT;
				key1_q  <= KEY1_INIT;
				key2_q  <= KEY2_INIT;
				save0_q <= KEY0_INIT;
				save1_q <= KEY1_INIT;
				save2_q <= KEY2_INIT;
			end else if (cmd.rewind) begin
				key0_q <= save0_q;
				key1_q <= save1_q;
				key2_q <= save2_q;
			end else if (cmd.step0) begin
				key0_q <= key0_next;
			end else if (cmd.step12) begin
				key1_q <= key1_next;
				key2_q <= key2_next;
				if (cmd.save) begin
					save0_q <= key0_q;
					save1_q <= key1_next;
					save2_q <= key2_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data) begin
			out_byte_q <= res;
			out_last_q <= in_last;
		end
	end

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule
`default_nettype wire

[design/zip_stream_cipher.sv]
// Top level of the zip stream cipher: controller and datapath.
// Depends on zsc_pkg, zsc_if, zsc_ctrl and zsc_datapath.
// Usage:
//   din carries one transaction per item: kind (start set-up, password byte,
//   data byte, rewind), byte_value and last_in. dout carries one result per
//   data byte: out_byte and last_out.
//   cfg_we/cfg_wdata set the decrypt mode (1 decrypt, 0 encrypt); write it
//   only while the block is idle.
// Timing:
//   Start and rewind load the keys on acceptance. Password and data bytes
//   are processed as the keystream multiply and key0 CRC step in the accept
//   cycle, then the key1 multiply and key2 CRC step; din is not ready again
//   until that second step is done. A result is visible on dout the cycle after
//   acceptance.
// Reset:
//   arst_n loads the initial keys into the key words and the saved copy,
//   clears the mode to encrypt and empties the result register.
// Stall:
//   A pending result holds on dout; din is not ready while the result
//   register is full and not being taken.
`timescale 1ns / 1ps
`default_nettype none
module zip_stream_cipher import zsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	zsc_in_if.sink    din,
	zsc_out_if.source dout
);

	cmd_t cmd;

	zsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_kind   (din.kind),
		.in_ready  (din.ready),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.cmd       (cmd)
	);

	zsc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.in_byte   (din.byte_value),
		.in_last   (din.last_in),
		.out_byte  (dout.out_byte),
		.out_last  (dout.last_out)
	);

endmodule
`default_nettype wire
